### hw/rtl/tcw_pkg.sv
// Shared types, constants and helpers of the text console writer.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

	// Screen geometry.
	localparam int COLUMNS    = 80;
	localparam int LINES      = 25;
	localparam int CELL_COUNT = COLUMNS * LINES;
	localparam int CELL_AW    = $clog2(CELL_COUNT);

	// Field widths of the item and result beats.
	localparam int ACT_W  = 3;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;
	localparam int COLOR_W = 8;

	// Cell contents.
	localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
	localparam logic [CELL_W-1:0]  RESET_CELL  = 16'h0720;

	// Action codes on the item channel.
	localparam logic [ACT_W-1:0] ACT_PUT       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_NEWLINE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_BACKSPACE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;

	// Command kinds after classification.
	typedef enum logic [2:0] {
		K_PUT,
		K_NEWLINE,
		K_BACKSPACE,
		K_CLEAR,
		K_READ,
		K_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [CHAR_W-1:0]   ch;
		logic [CELL_AW-1:0]  addr;
	} cmd_t;

	// Linear cell address of a row and column.
	function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return CELL_AW'(row) * CELL_AW'(COLUMNS) + CELL_AW'(col);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/tcw_front.sv
// Front end: accepts item beats, classifies them and queues the commands.
`timescale 1ns / 1ps
`default_nettype none
module tcw_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic [tcw_pkg::ACT_W-1:0]   action,
	input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  wire logic [tcw_pkg::IDX_W-1:0]   cell_index,
	input  wire logic                        enable,
	output logic                             cmd_valid,
	output tcw_pkg::cmd_t                    cmd,
	input  wire logic                        cmd_pop
);

	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);

	tcw_pkg::cmd_t      queue_q [QDEPTH];
	logic [QPW-1:0]     wr_ptr_q;
	logic [QPW-1:0]     rd_ptr_q;
	logic [QPW:0]       count_q;
	tcw_pkg::cmd_t      cmd_in;
	logic               push;

	// Classify the action; an out-of-range read returns a zero word.
	always_comb begin
		cmd_in.ch   = char_code;
		cmd_in.addr = tcw_pkg::CELL_AW'(cell_index);
		unique case (action)
			tcw_pkg::ACT_PUT:       cmd_in.kind = tcw_pkg::K_PUT;
			tcw_pkg::ACT_NEWLINE:   cmd_in.kind = tcw_pkg::K_NEWLINE;
			tcw_pkg::ACT_BACKSPACE: cmd_in.kind = tcw_pkg::K_BACKSPACE;
			tcw_pkg::ACT_CLEAR:     cmd_in.kind = tcw_pkg::K_CLEAR;
			tcw_pkg::ACT_READ: begin
				if (32'(cell_index) < 32'(tcw_pkg::CELL_COUNT)) begin
					cmd_in.kind = tcw_pkg::K_READ;
				end else begin
					cmd_in.kind = tcw_pkg::K_NOP;
				end
			end
			default:                cmd_in.kind = tcw_pkg::K_NOP;
		endcase
	end

	assign item_stall = !enable || (count_q == (QPW+1)'(QDEPTH));
	assign push       = item_valid && !item_stall;
	assign cmd_valid  = (count_q != '0);
	assign cmd        = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (cmd_pop && !push) begin
				count_q <= count_q - (QPW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tcw_back.sv
// Back end: sequencer that carries out commands on the screen store.
`timescale 1ns / 1ps
`default_nettype none
module tcw_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write_en,
	input  wire logic [tcw_pkg::COLOR_W-1:0]  cfg_write_data,
	input  wire logic                         cmd_valid,
	input  wire tcw_pkg::cmd_t                cmd,
	output logic                              cmd_pop,
	output logic                              init_done,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic      [tcw_pkg::COL_W-1:0]    cursor_column,
	output logic      [tcw_pkg::ROW_W-1:0]    cursor_row,
	output logic      [tcw_pkg::POS_W-1:0]    cursor_pos,
	output logic      [tcw_pkg::CELL_W-1:0]   cell_word
);

	localparam int AW = tcw_pkg::CELL_AW;

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_READ   = 7'b0000100,
		S_SCROLL = 7'b0001000,
		S_BLANK  = 7'b0010000,
		S_CLEAR  = 7'b0100000,
		S_RESP   = 7'b1000000
	} seq_state_t;

	seq_state_t                     state_q;
	seq_state_t                     scroll_first;
	logic [AW-1:0]                  cnt_q;
	logic [AW-1:0]                  scroll_start;
	logic [tcw_pkg::ROW_W-1:0]      row_q;
	logic [tcw_pkg::COL_W-1:0]      col_q;
	logic [tcw_pkg::POS_W-1:0]      shown_q;
	logic [tcw_pkg::COLOR_W-1:0]    color_q;
	logic                           latch_q;
	logic                           out_valid_q;
	logic                           copy_vld_s1;
	logic [AW-1:0]                  copy_addr_s1;
	logic [tcw_pkg::CELL_W-1:0]     word_q;
	logic [tcw_pkg::COL_W-1:0]      out_col_q;
	logic [tcw_pkg::ROW_W-1:0]      out_row_q;
	logic [tcw_pkg::POS_W-1:0]      out_pos_q;
	logic [tcw_pkg::CELL_W-1:0]     out_word_q;

	logic [tcw_pkg::COL_W:0]        col_inc;
	logic                           wrap;
	logic                           last_row;
	logic                           bs_origin;
	logic [tcw_pkg::COL_W-1:0]      bs_col;
	logic [tcw_pkg::ROW_W-1:0]      bs_row;
	logic [AW-1:0]                  here_addr;
	logic [AW-1:0]                  bs_addr;
	logic [tcw_pkg::CELL_W-1:0]     blank_cell;
	logic [tcw_pkg::POS_W-1:0]      shown_next;
	logic                           cnt_last;
	logic                           resp_fire;

	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr;
	logic [tcw_pkg::CELL_W-1:0]     mem_wdata;
	logic [AW-1:0]                  mem_raddr;
	logic [tcw_pkg::CELL_W-1:0]     mem_rdata;

	// Cursor arithmetic.
	always_comb begin
		col_inc    = {1'b0, col_q} + (tcw_pkg::COL_W+1)'(1);
		wrap       = (col_inc == (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS));
		last_row   = (row_q == tcw_pkg::ROW_W'(tcw_pkg::LINES - 1));
		bs_origin  = (col_q == '0) && (row_q == '0);
		if (col_q == '0) begin
			bs_col = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
			bs_row = row_q - tcw_pkg::ROW_W'(1);
		end else begin
			bs_col = col_q - tcw_pkg::COL_W'(1);
			bs_row = row_q;
		end
		here_addr  = tcw_pkg::cell_addr(row_q, col_q);
		bs_addr    = tcw_pkg::cell_addr(bs_row, bs_col);
		blank_cell = {color_q, tcw_pkg::BLANK_CHAR};
		shown_next = latch_q ? tcw_pkg::POS_W'(here_addr) : shown_q;
		cnt_last   = (cnt_q == AW'(tcw_pkg::CELL_COUNT - 1));
		resp_fire  = (state_q == S_RESP) && (!out_valid_q || !result_stall);
		// A one-row screen has nothing to move up: go straight to blanking.
		if (tcw_pkg::LINES > 1) begin
			scroll_first = S_SCROLL;
			scroll_start = AW'(tcw_pkg::COLUMNS);
		end else begin
			scroll_first = S_BLANK;
			scroll_start = AW'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
		end
	end

	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign init_done = (state_q != S_INIT);

	// Memory port selection; the delayed scroll copy owns the write port.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = blank_cell;
		mem_raddr = (state_q == S_IDLE) ? cmd.addr : cnt_q;
		if (copy_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = copy_addr_s1;
			mem_wdata = mem_rdata;
		end else begin
			unique case (state_q)
				S_INIT: begin
					mem_we    = 1'b1;
					mem_wdata = tcw_pkg::RESET_CELL;
				end
				S_IDLE: begin
					if (cmd_valid && cmd.kind == tcw_pkg::K_PUT) begin
						mem_we    = 1'b1;
						mem_waddr = here_addr;
						mem_wdata = {color_q, cmd.ch};
					end else if (cmd_valid && cmd.kind == tcw_pkg::K_BACKSPACE
						&& !bs_origin) begin
						mem_we    = 1'b1;
						mem_waddr = bs_addr;
					end
				end
				S_BLANK, S_CLEAR: begin
					mem_we = 1'b1;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(tcw_pkg::CELL_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			shown_q     <= '0;
			color_q     <= tcw_pkg::RESET_COLOR;
			latch_q     <= 1'b0;
			out_valid_q <= 1'b0;
			copy_vld_s1 <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				color_q <= cfg_write_data;
			end
			copy_vld_s1 <= 1'b0;
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						latch_q <= 1'b0;
						unique case (cmd.kind)
							tcw_pkg::K_PUT, tcw_pkg::K_NEWLINE: begin
								latch_q <= 1'b1;
								if (cmd.kind == tcw_pkg::K_PUT && !wrap) begin
									col_q   <= col_inc[tcw_pkg::COL_W-1:0];
									state_q <= S_RESP;
								end else begin
									col_q <= '0;
									if (last_row) begin
										state_q <= scroll_first;
										cnt_q   <= scroll_start;
									end else begin
										row_q   <= row_q + tcw_pkg::ROW_W'(1);
										state_q <= S_RESP;
									end
								end
							end
							tcw_pkg::K_BACKSPACE: begin
								if (!bs_origin) begin
									latch_q <= 1'b1;
									col_q   <= bs_col;
									row_q   <= bs_row;
								end
								state_q <= S_RESP;
							end
							tcw_pkg::K_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								cnt_q   <= '0;
								state_q <= S_CLEAR;
							end
							tcw_pkg::K_READ: begin
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_RESP;
				end
				S_SCROLL: begin
					copy_vld_s1 <= 1'b1;
					if (cnt_last) begin
						state_q <= S_BLANK;
						cnt_q   <= AW'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				S_BLANK: begin
					if (!copy_vld_s1) begin
						if (cnt_last) begin
							state_q <= S_RESP;
						end else begin
							cnt_q <= cnt_q + AW'(1);
						end
					end
				end
				S_CLEAR: begin
					if (cnt_last) begin
						state_q <= S_RESP;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				S_RESP: begin
					if (resp_fire) begin
						out_valid_q <= 1'b1;
						shown_q     <= shown_next;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCROLL) begin
			copy_addr_s1 <= cnt_q - AW'(tcw_pkg::COLUMNS);
		end
		if (cmd_pop) begin
			word_q <= '0;
		end else if (state_q == S_READ) begin
			word_q <= mem_rdata;
		end
		if (resp_fire) begin
			out_col_q  <= col_q;
			out_row_q  <= row_q;
			out_pos_q  <= shown_next;
			out_word_q <= word_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign cursor_column = out_col_q;
	assign cursor_row    = out_row_q;
	assign cursor_pos    = out_pos_q;
	assign cell_word     = out_word_q;

endmodule
`default_nettype wire

### hw/rtl/text_console_writer.sv
// Top level of the text console writer: front end, command queue and back end.
`timescale 1ns / 1ps
`default_nettype none
// Text console engine over an 80x25 screen store of 16-bit cells
// (attribute in the high byte, character in the low byte).
// Item channel: item_valid / item_stall with action, char_code and
//   cell_index; a beat moves when valid is high and stall is low.
// Result channel: result_valid / result_stall with the cursor column and
//   row after the action, the hardware cursor position and, for a read,
//   the cell word. Exactly one result beat follows every item beat.
// Configuration: cfg_write_en / cfg_write_data load the attribute byte
//   used for every write and blank; write it only while the block is idle.
// Items land in a two-entry command queue, so the front keeps taking beats
//   while the back end works or a result waits on a stalled receiver.
// Each item passes through the queue and the idle and response states of the
//   back end; a read also passes through the read state. A scroll copies
//   1920 cells up one row, then blanks the 80 cells of the bottom row, and a
//   clear writes the whole store at one cell per cycle.
// Reset: the cursor, the hardware cursor and the attribute (grey on black)
//   are reset at once; then a clearing pass fills all 2000 cells of the store
//   with blanks while item_stall is held high.
// A stalled receiver holds the result register; the back end then waits
//   with its next result, and the queue fills and raises item_stall.
module text_console_writer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write_en,
	input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_write_data,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [tcw_pkg::ACT_W-1:0]     action,
	input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  wire logic [tcw_pkg::IDX_W-1:0]     cell_index,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic      [tcw_pkg::COL_W-1:0]     cursor_column,
	output logic      [tcw_pkg::ROW_W-1:0]     cursor_row,
	output logic      [tcw_pkg::POS_W-1:0]     cursor_pos,
	output logic      [tcw_pkg::CELL_W-1:0]    cell_word
);

	logic          cmd_valid;
	logic          cmd_pop;
	logic          init_done;
	tcw_pkg::cmd_t cmd;

	// Accept and classify beats; hold them until the back end pops.
	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action    (action),
		.char_code (char_code),
		.cell_index(cell_index),
		.enable    (init_done),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Run each command against the screen store and register its result.
	tcw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.init_done     (init_done),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row),
		.cursor_pos    (cursor_pos),
		.cell_word     (cell_word)
	);

	// A reported cursor always lies on the screen.
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(cursor_column) < tcw_pkg::COLUMNS)
			&& (32'(cursor_row) < tcw_pkg::LINES))
		else $error("cursor off screen in result beat");

	// The back end pops only a queued command.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	// No item beat moves during the clearing pass after reset.
	a_stall_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> item_stall && !cmd_valid)
		else $error("item taken during clearing pass");

endmodule
`default_nettype wire
